/* rtl/clns_pkg.sv */
// Shared constants, codes and helper functions of the cell-list neighbor search.
package clns_pkg;

   localparam int AXIS_CAP     = 4096;
   localparam int AXIS_W       = 13;
   localparam int CELL_W       = 12;
   localparam int BOX_W        = 22;
   localparam int DIST_W       = 44;
   localparam int LIMIT_W      = 7;
   localparam int MODE_W       = 2;
   localparam int STATUS_W     = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 44;

   localparam int DEF_MAX_CELLS      = 4096;
   localparam int DEF_SLOTS_PER_CELL = 16;
   localparam int DEF_MAX_NEIGHBORS  = 64;
   localparam int DEF_COORD_BITS     = 22;
   localparam int DEF_ID_BITS        = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_CLEAR  = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED = 3'd0,
      STATUS_FULL     = 3'd1,
      STATUS_OUTSIDE  = 3'd2,
      STATUS_NEIGHBOR = 3'd3,
      STATUS_NONE     = 3'd4,
      STATUS_CLEARED  = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CELLS_X        = 3'd0,
      REG_CELLS_Y        = 3'd1,
      REG_CELLS_Z        = 3'd2,
      REG_BOX_LX         = 3'd3,
      REG_BOX_LY         = 3'd4,
      REG_BOX_LZ         = 3'd5,
      REG_CUTOFF_SQ      = 3'd6,
      REG_NEIGHBOR_LIMIT = 3'd7
   } csr_reg_type;

   function automatic logic [AXIS_W-1:0] axis_eff(input logic [AXIS_W-1:0] n);
      begin
         if (n == '0) begin
            axis_eff = AXIS_W'(1);
         end else if (n > AXIS_W'(AXIS_CAP)) begin
            axis_eff = AXIS_W'(AXIS_CAP);
         end else begin
            axis_eff = n;
         end
      end
   endfunction

   function automatic logic [1:0] axis_count(input logic [AXIS_W-1:0] n);
      begin
         if (n >= AXIS_W'(3)) begin
            axis_count = 2'd3;
         end else begin
            axis_count = n[1:0];
         end
      end
   endfunction

   function automatic logic [CELL_W-1:0] axis_cand(input logic [CELL_W-1:0] c,
                                                  input logic [AXIS_W-1:0] n,
                                                  input logic [1:0] j);
      logic [AXIS_W-1:0] up;
      begin
         up = {1'b0, c} + AXIS_W'(1);
         case (j)
            2'd0:    axis_cand = (c == '0) ? CELL_W'(n - AXIS_W'(1)) : c - CELL_W'(1);
            2'd1:    axis_cand = c;
            default: axis_cand = (up >= n) ? '0 : up[CELL_W-1:0];
         endcase
      end
   endfunction

endpackage

/* rtl/clns_if.sv */
// Request, response and register write channel interfaces.
interface clns_req_if import clns_pkg::*; #(
   parameter int ID_BITS    = DEF_ID_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS
) ();
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [ID_BITS-1:0]    atom_id;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic [COORD_BITS-1:0] pos_z;
   modport source(output valid, mode, atom_id, pos_x, pos_y, pos_z, input ready);
   modport sink(input valid, mode, atom_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface clns_rsp_if import clns_pkg::*; #(
   parameter int ID_BITS = DEF_ID_BITS
) ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_BITS-1:0]  neighbor_id;
   logic [DIST_W-1:0]   neighbor_dist_sq;
   logic                last;
   modport source(output valid, status, neighbor_id, neighbor_dist_sq, last, input ready);
   modport sink(input valid, status, neighbor_id, neighbor_dist_sq, last, output ready);
endinterface

interface clns_csr_if import clns_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

/* rtl/clns_div.sv */
// Restoring divider, one quotient bit per cycle.
module clns_div #(
   parameter int AW = 22,
   localparam int SW = $clog2(AW + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [SW-1:0] steps,
   input  logic [AW-1:0] rem_init,
   input  logic [AW-1:0] bits,
   input  logic [AW-1:0] divisor,
   output logic [AW-1:0] quotient,
   output logic [AW-1:0] remainder,
   output logic          busy
);
   logic [AW-1:0] rem_ff, rem_in;
   logic [AW-1:0] bits_ff, bits_in;
   logic [AW-1:0] quo_ff, quo_in;
   logic [AW-1:0] div_ff;
   logic [SW-1:0] cnt_ff;
   logic [AW:0]   trial;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, bits_ff[AW-1]};
      ge      = trial >= {1'b0, div_ff};
      rem_in  = ge ? AW'(trial - {1'b0, div_ff}) : trial[AW-1:0];
      quo_in  = {quo_ff[AW-2:0], ge};
      bits_in = {bits_ff[AW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= steps;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= rem_init;
         bits_ff <= bits;
         quo_ff  <= '0;
         div_ff  <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff  <= rem_in;
         bits_ff <= bits_in;
         quo_ff  <= quo_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign busy      = cnt_ff != '0;
endmodule

/* rtl/cell_list_neighbor_search.sv */
// Top level: periodic cell-list neighbor search over fill and slot memories.
//
//  channel  | dir | handshake     | payload
//  req_bus  | in  | valid/ready   | mode, atom_id, pos_x, pos_y, pos_z
//  rsp_bus  | out | valid/ready   | status, neighbor_id, neighbor_dist_sq, last
//  csr_bus  | in  | valid/ready   | index, data
//
// Insert: each coordinate is binned by a 12-step division, one per axis, run side by side.
// Query: each neighbor cell is visited, each stored atom is tested and the query's own atom
// skipped, with a modulo division when an axis gap reaches the box; the slot memory read port
// is walked one slot at a time.
// Reset and every clear request sweep all MAX_CELLS entries of the fill memory, no requests taken.
// Results stall in the output register; the next request is taken once the walk ends.
module cell_list_neighbor_search import clns_pkg::*; #(
   parameter int MAX_CELLS      = DEF_MAX_CELLS,
   parameter int SLOTS_PER_CELL = DEF_SLOTS_PER_CELL,
   parameter int MAX_NEIGHBORS  = DEF_MAX_NEIGHBORS,
   parameter int COORD_BITS     = DEF_COORD_BITS,
   parameter int ID_BITS        = DEF_ID_BITS
) (
   input logic      clock,
   input logic      reset,
   clns_req_if.sink   req_bus,
   clns_rsp_if.source rsp_bus,
   clns_csr_if.sink   csr_bus
);
   localparam int AW     = (COORD_BITS > BOX_W) ? COORD_BITS : BOX_W;
   localparam int SW     = $clog2(AW + 1);
   localparam int CI_W   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int SA_W   = (MAX_CELLS * SLOTS_PER_CELL > 1) ?
                           $clog2(MAX_CELLS * SLOTS_PER_CELL) : 1;
   localparam int FW     = $clog2(SLOTS_PER_CELL + 1);
   localparam int NW     = $clog2(MAX_NEIGHBORS + 1);
   localparam int PW     = AW + AXIS_W;
   localparam int T1_W   = CELL_W + AXIS_W + 1;
   localparam int FL_W   = T1_W + AXIS_W;
   localparam int SUM_W  = 2 * AW + 2;
   localparam int SLOT_W = ID_BITS + 3 * COORD_BITS;

   typedef enum logic [4:0] {
      ST_SWEEP, ST_IDLE, ST_MUL, ST_BIN, ST_BINW, ST_CELL1, ST_CELL2, ST_CELL3,
      ST_FILLW, ST_SLOT, ST_SLOTW, ST_MODCHK, ST_DIVW, ST_GAP, ST_SQ, ST_SUM,
      ST_CMP, ST_NEXT, ST_FINAL, ST_EMIT
   } state_type;

   // configuration
   logic [AXIS_W-1:0]  ncell_ff [3];
   logic [BOX_W-1:0]   box_ff [3];
   logic [DIST_W-1:0]  cutoff_ff;
   logic [LIMIT_W-1:0] limit_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            ncell_ff[k] <= AXIS_W'(1);
            box_ff[k]   <= '1;
         end
         cutoff_ff <= '0;
         limit_ff  <= LIMIT_W'(64);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_CELLS_X:        ncell_ff[0] <= csr_bus.data[AXIS_W-1:0];
            REG_CELLS_Y:        ncell_ff[1] <= csr_bus.data[AXIS_W-1:0];
            REG_CELLS_Z:        ncell_ff[2] <= csr_bus.data[AXIS_W-1:0];
            REG_BOX_LX:         box_ff[0]   <= csr_bus.data[BOX_W-1:0];
            REG_BOX_LY:         box_ff[1]   <= csr_bus.data[BOX_W-1:0];
            REG_BOX_LZ:         box_ff[2]   <= csr_bus.data[BOX_W-1:0];
            REG_CUTOFF_SQ:      cutoff_ff   <= csr_bus.data[DIST_W-1:0];
            REG_NEIGHBOR_LIMIT: limit_ff    <= csr_bus.data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath state
   state_type          state_ff, ret_ff;
   logic               sweep_rsp_ff;
   logic [CI_W-1:0]    clr_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [ID_BITS-1:0] id_ff;
   logic [AW-1:0]      pos_ff [3];
   logic [PW-1:0]      prod_ff [3];
   logic [CELL_W-1:0]  cell_ff [3];
   logic [1:0]         idx_ff [3];
   logic [T1_W-1:0]    t1_ff;
   logic [FL_W-1:0]    flat_ff;
   logic [FW-1:0]      fill_cur_ff;
   logic [FW-1:0]      slot_i_ff;
   logic [NW-1:0]      found_ff;
   logic [AW-1:0]      d_ff [3];
   logic [AW-1:0]      g_ff [3];
   logic [2*AW-1:0]    sq_ff [3];
   logic [SUM_W-1:0]   sum_ff;
   logic [ID_BITS-1:0] cand_id_ff;
   logic               pend_valid_ff;
   logic [ID_BITS-1:0] pend_id_ff;
   logic [DIST_W-1:0]  pend_dist_ff;
   status_type         em_status_ff;
   logic [ID_BITS-1:0] em_id_ff;
   logic [DIST_W-1:0]  em_dist_ff;
   logic               em_last_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [ID_BITS-1:0] rsp_id_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic               rsp_last_ff;

   logic [AXIS_W-1:0]  n_eff [3];
   logic [1:0]         n_cnt [3];
   logic [AW-1:0]      box_w [3];
   logic [CELL_W-1:0]  cur [3];
   logic [AW-1:0]      req_pos [3];
   logic [NW-1:0]      lim;
   logic               outside;
   logic               in_range;
   logic               need_mod;
   logic               is_insert;

   // memories
   logic [FW-1:0]      fill_mem [MAX_CELLS];
   logic [FW-1:0]      fill_rd_ff;
   logic               fill_we;
   logic [CI_W-1:0]    fill_wa;
   logic [FW-1:0]      fill_wd;
   logic [SLOT_W-1:0]  slot_mem [MAX_CELLS * SLOTS_PER_CELL];
   logic [SLOT_W-1:0]  slot_rd_ff;
   logic               slot_we;
   logic [SA_W-1:0]    slot_wa;
   logic [SA_W-1:0]    slot_ra;
   logic [SA_W-1:0]    slot_base;
   logic [ID_BITS-1:0]    rd_id;
   logic [COORD_BITS-1:0] rd_pos [3];

   // dividers
   logic          div_start;
   logic [SW-1:0] div_steps;
   logic [AW-1:0] div_rem_init [3];
   logic [AW-1:0] div_bits [3];
   logic [AW-1:0] div_quo [3];
   logic [AW-1:0] div_rem [3];
   logic          div_busy [3];

   assign req_pos[0] = AW'(req_bus.pos_x);
   assign req_pos[1] = AW'(req_bus.pos_y);
   assign req_pos[2] = AW'(req_bus.pos_z);

   always_comb begin
      is_insert = mode_ff == MODE_INSERT;
      outside   = 1'b0;
      need_mod  = 1'b0;
      for (int k = 0; k < 3; k++) begin
         n_eff[k] = axis_eff(ncell_ff[k]);
         n_cnt[k] = axis_count(n_eff[k]);
         box_w[k] = AW'(box_ff[k]);
         cur[k]   = is_insert ? cell_ff[k] : axis_cand(cell_ff[k], n_eff[k], idx_ff[k]);
         if (req_pos[k] >= box_w[k]) outside = 1'b1;
         if (d_ff[k] >= box_w[k]) need_mod = 1'b1;
      end
      lim      = (limit_ff > LIMIT_W'(MAX_NEIGHBORS)) ? NW'(MAX_NEIGHBORS) : NW'(limit_ff);
      in_range = flat_ff < FL_W'(MAX_CELLS);
   end

   always_comb begin
      div_start = (state_ff == ST_BIN) || (state_ff == ST_MODCHK && need_mod);
      div_steps = (state_ff == ST_BIN) ? SW'(CELL_W) : SW'(AW);
      for (int k = 0; k < 3; k++) begin
         if (state_ff == ST_BIN) begin
            div_rem_init[k] = AW'(prod_ff[k][PW-1:CELL_W]);
            div_bits[k]     = {prod_ff[k][CELL_W-1:0], (AW - CELL_W)'(0)};
         end else begin
            div_rem_init[k] = '0;
            div_bits[k]     = d_ff[k];
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_div
      clns_div #(.AW(AW)) u_div (
         .clock     (clock),
         .reset     (reset),
         .start     (div_start),
         .steps     (div_steps),
         .rem_init  (div_rem_init[k]),
         .bits      (div_bits[k]),
         .divisor   (box_w[k]),
         .quotient  (div_quo[k]),
         .remainder (div_rem[k]),
         .busy      (div_busy[k])
      );
   end

   // memory ports
   always_comb begin
      fill_we   = 1'b0;
      fill_wa   = flat_ff[CI_W-1:0];
      fill_wd   = fill_rd_ff + FW'(1);
      slot_we   = 1'b0;
      slot_base = SA_W'(flat_ff[CI_W-1:0]) * SA_W'(SLOTS_PER_CELL);
      slot_wa   = slot_base + SA_W'(fill_rd_ff);
      slot_ra   = slot_base + SA_W'(slot_i_ff);
      if (state_ff == ST_SWEEP) begin
         fill_we = 1'b1;
         fill_wa = clr_ff;
         fill_wd = '0;
      end else if (state_ff == ST_FILLW && is_insert &&
                   fill_rd_ff < FW'(SLOTS_PER_CELL)) begin
         fill_we = 1'b1;
         slot_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[fill_wa] <= fill_wd;
      fill_rd_ff <= fill_mem[flat_ff[CI_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= {id_ff, pos_ff[0][COORD_BITS-1:0],
                                         pos_ff[1][COORD_BITS-1:0],
                                         pos_ff[2][COORD_BITS-1:0]};
      slot_rd_ff <= slot_mem[slot_ra];
   end

   assign rd_id     = slot_rd_ff[SLOT_W-1 -: ID_BITS];
   assign rd_pos[0] = slot_rd_ff[3*COORD_BITS-1 -: COORD_BITS];
   assign rd_pos[1] = slot_rd_ff[2*COORD_BITS-1 -: COORD_BITS];
   assign rd_pos[2] = slot_rd_ff[COORD_BITS-1:0];

   assign req_bus.ready            = state_ff == ST_IDLE;
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_status_ff;
   assign rsp_bus.neighbor_id      = rsp_id_ff;
   assign rsp_bus.neighbor_dist_sq = rsp_dist_ff;
   assign rsp_bus.last             = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         ret_ff        <= ST_IDLE;
         sweep_rsp_ff  <= 1'b0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         found_ff      <= '0;
      end else begin
         if (rsp_bus.ready && state_ff != ST_EMIT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_SWEEP: begin
               if (clr_ff == CI_W'(MAX_CELLS - 1)) begin
                  clr_ff <= '0;
                  if (sweep_rsp_ff) begin
                     em_status_ff <= STATUS_CLEARED;
                     em_id_ff     <= '0;
                     em_dist_ff   <= '0;
                     em_last_ff   <= 1'b1;
                     ret_ff       <= ST_IDLE;
                     state_ff     <= ST_EMIT;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  clr_ff <= clr_ff + CI_W'(1);
               end
            end
            ST_IDLE: begin
               if (req_bus.valid) begin
                  mode_ff <= req_bus.mode;
                  id_ff   <= req_bus.atom_id;
                  for (int k = 0; k < 3; k++) pos_ff[k] <= req_pos[k];
                  em_id_ff   <= '0;
                  em_dist_ff <= '0;
                  em_last_ff <= 1'b1;
                  ret_ff     <= ST_IDLE;
                  case (req_bus.mode) inside
                     MODE_CLEAR: begin
                        sweep_rsp_ff <= 1'b1;
                        clr_ff       <= '0;
                        state_ff     <= ST_SWEEP;
                     end
                     MODE_INSERT, MODE_QUERY: begin
                        if (outside) begin
                           em_status_ff <= STATUS_OUTSIDE;
                           state_ff     <= ST_EMIT;
                        end else begin
                           state_ff <= ST_MUL;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_MUL: begin
               for (int k = 0; k < 3; k++) prod_ff[k] <= PW'(pos_ff[k]) * PW'(n_eff[k]);
               state_ff <= ST_BIN;
            end
            ST_BIN: state_ff <= ST_BINW;
            ST_BINW: begin
               if (!div_busy[0]) begin
                  for (int k = 0; k < 3; k++) begin
                     cell_ff[k] <= div_quo[k][CELL_W-1:0];
                     idx_ff[k]  <= '0;
                  end
                  found_ff      <= '0;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_CELL1;
               end
            end
            ST_CELL1: begin
               t1_ff    <= T1_W'(cur[0]) * T1_W'(n_eff[1]) + T1_W'(cur[1]);
               state_ff <= ST_CELL2;
            end
            ST_CELL2: begin
               flat_ff  <= FL_W'(t1_ff) * FL_W'(n_eff[2]) + FL_W'(cur[2]);
               state_ff <= ST_CELL3;
            end
            ST_CELL3: begin
               if (in_range) begin
                  state_ff <= ST_FILLW;
               end else if (is_insert) begin
                  em_status_ff <= STATUS_FULL;
                  state_ff     <= ST_EMIT;
               end else begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_FILLW: begin
               if (is_insert) begin
                  em_status_ff <= (fill_rd_ff < FW'(SLOTS_PER_CELL)) ?
                                  STATUS_INSERTED : STATUS_FULL;
                  state_ff     <= ST_EMIT;
               end else begin
                  fill_cur_ff <= fill_rd_ff;
                  slot_i_ff   <= '0;
                  state_ff    <= ST_SLOT;
               end
            end
            ST_SLOT: begin
               if (slot_i_ff >= fill_cur_ff || found_ff >= lim) begin
                  state_ff <= ST_NEXT;
               end else begin
                  state_ff <= ST_SLOTW;
               end
            end
            ST_SLOTW: begin
               if (rd_id == id_ff) begin
                  slot_i_ff <= slot_i_ff + FW'(1);
                  state_ff  <= ST_SLOT;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     d_ff[k] <= (pos_ff[k] > AW'(rd_pos[k])) ? pos_ff[k] - AW'(rd_pos[k])
                                                             : AW'(rd_pos[k]) - pos_ff[k];
                  end
                  cand_id_ff <= rd_id;
                  state_ff   <= ST_MODCHK;
               end
            end
            ST_MODCHK: state_ff <= need_mod ? ST_DIVW : ST_GAP;
            ST_DIVW: begin
               if (!div_busy[0]) begin
                  for (int k = 0; k < 3; k++) d_ff[k] <= div_rem[k];
                  state_ff <= ST_GAP;
               end
            end
            ST_GAP: begin
               for (int k = 0; k < 3; k++) begin
                  g_ff[k] <= (box_w[k] - d_ff[k] < d_ff[k]) ? box_w[k] - d_ff[k] : d_ff[k];
               end
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               for (int k = 0; k < 3; k++) sq_ff[k] <= g_ff[k] * g_ff[k];
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               sum_ff   <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               slot_i_ff <= slot_i_ff + FW'(1);
               if (sum_ff < SUM_W'(cutoff_ff)) begin
                  found_ff      <= found_ff + NW'(1);
                  pend_valid_ff <= 1'b1;
                  pend_id_ff    <= cand_id_ff;
                  pend_dist_ff  <= sum_ff[DIST_W-1:0];
                  if (pend_valid_ff) begin
                     em_status_ff <= STATUS_NEIGHBOR;
                     em_id_ff     <= pend_id_ff;
                     em_dist_ff   <= pend_dist_ff;
                     em_last_ff   <= 1'b0;
                     ret_ff       <= ST_SLOT;
                     state_ff     <= ST_EMIT;
                  end else begin
                     state_ff <= ST_SLOT;
                  end
               end else begin
                  state_ff <= ST_SLOT;
               end
            end
            ST_NEXT: begin
               if ({1'b0, idx_ff[2]} + 3'd1 < {1'b0, n_cnt[2]}) begin
                  idx_ff[2] <= idx_ff[2] + 2'd1;
                  state_ff  <= ST_CELL1;
               end else begin
                  idx_ff[2] <= '0;
                  if ({1'b0, idx_ff[1]} + 3'd1 < {1'b0, n_cnt[1]}) begin
                     idx_ff[1] <= idx_ff[1] + 2'd1;
                     state_ff  <= ST_CELL1;
                  end else begin
                     idx_ff[1] <= '0;
                     if ({1'b0, idx_ff[0]} + 3'd1 < {1'b0, n_cnt[0]}) begin
                        idx_ff[0] <= idx_ff[0] + 2'd1;
                        state_ff  <= ST_CELL1;
                     end else begin
                        state_ff <= ST_FINAL;
                     end
                  end
               end
            end
            ST_FINAL: begin
               em_status_ff <= pend_valid_ff ? STATUS_NEIGHBOR : STATUS_NONE;
               em_id_ff     <= pend_valid_ff ? pend_id_ff : '0;
               em_dist_ff   <= pend_valid_ff ? pend_dist_ff : '0;
               em_last_ff   <= 1'b1;
               ret_ff       <= ST_IDLE;
               state_ff     <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= em_status_ff;
                  rsp_id_ff     <= em_id_ff;
                  rsp_dist_ff   <= em_dist_ff;
                  rsp_last_ff   <= em_last_ff;
                  state_ff      <= ret_ff;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_found_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SLOT) |-> (found_ff <= lim))
      else $error("neighbor count above limit");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != STATUS_NEIGHBOR) |->
      (rsp_bus.neighbor_id == '0 && rsp_bus.neighbor_dist_sq == '0))
      else $error("payload not zero on non-neighbor response");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy[0])
      else $error("divider restarted while busy");

   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |=> !(rsp_valid_ff && rsp_status_ff == STATUS_NEIGHBOR &&
                                  $rose(rsp_valid_ff)))
      else $error("neighbor response during clearing sweep");
endmodule

/* tb/sv/cell_list_neighbor_search_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the cell-list neighbor search: directed and random requests.
module cell_list_neighbor_search_test;
   import clns_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam longint unsigned COORD_MAX = 64'h3FFFFF;
   localparam longint unsigned DIST_MAX  = 64'hFFF_FFFF_FFFF;
   localparam int WATCHDOG_LIMIT = 100000;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [15:0]       id;
      logic [21:0]       x;
      logic [21:0]       y;
      logic [21:0]       z;
   } search_req_t;

   typedef struct {
      status_type  status;
      logic [15:0] id;
      logic [43:0] dist_sq;
      logic        last;
   } search_rsp_t;

   logic clock;
   logic reset;

   clns_req_if req_bus ();
   clns_rsp_if rsp_bus ();
   clns_csr_if csr_bus ();

   cell_list_neighbor_search DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   search_req_t pending_requests[$];
   search_rsp_t expected_results[$];
   search_req_t stored_atoms[$];

   longint unsigned grid_reg[3];
   longint unsigned box_reg[3];
   longint unsigned cutoff_reg;
   longint unsigned limit_reg;

   logic [4:0]  cell_fill[4096];
   logic [15:0] slot_id[65536];
   logic [21:0] slot_x[65536];
   logic [21:0] slot_y[65536];
   logic [21:0] slot_z[65536];

   int errors;
   int req_gap;
   int rsp_wait;
   int rsp_hold;
   bit req_fired;
   bit idle_off;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned eff_cells(longint unsigned n);
      if (n == 0) return 1;
      if (n > AXIS_CAP) return AXIS_CAP;
      return n;
   endfunction

   function automatic longint unsigned wrap_gap_sq(longint unsigned a, longint unsigned b,
                                                   longint unsigned box);
      longint unsigned d;
      d = (a > b) ? a - b : b - a;
      d = d % box;
      if (box - d < d) d = box - d;
      return d * d;
   endfunction

   function automatic int neighbor_cells(longint unsigned c, longint unsigned n,
                                         output longint unsigned lst[3]);
      longint unsigned cand[3];
      int cnt;
      bit dup;
      cnt = 0;
      cand[0] = (c == 0) ? n - 1 : c - 1;
      cand[1] = c;
      cand[2] = (c + 1 >= n) ? 0 : c + 1;
      for (int i = 0; i < 3; i++) begin
         dup = 0;
         for (int j = 0; j < cnt; j++) if (lst[j] == cand[i]) dup = 1;
         if (!dup) begin
            lst[cnt] = cand[i];
            cnt++;
         end
      end
      return cnt;
   endfunction

   function automatic void push_result(status_type st, logic [15:0] id, logic [43:0] dist_sq,
                                       logic last);
      search_rsp_t o;
      o.status = st;
      o.id = id;
      o.dist_sq = dist_sq;
      o.last = last;
      expected_results.insert(expected_results.size(), o);
   endfunction

   function automatic void predict_search(search_req_t r);
      longint unsigned nx, ny, nz, cx, cy, cz, flat, s, d, lim;
      longint unsigned lx[3], ly[3], lz[3];
      int kx, ky, kz, found;
      nx = eff_cells(grid_reg[0]);
      ny = eff_cells(grid_reg[1]);
      nz = eff_cells(grid_reg[2]);
      if (r.mode == MODE_CLEAR) begin
         foreach (cell_fill[i]) cell_fill[i] = '0;
         push_result(STATUS_CLEARED, '0, '0, 1'b1);
         return;
      end
      if (r.mode == MODE_UNUSED) return;
      if (r.x >= box_reg[0] || r.y >= box_reg[1] || r.z >= box_reg[2]) begin
         push_result(STATUS_OUTSIDE, '0, '0, 1'b1);
         return;
      end
      cx = longint'(r.x) * nx / box_reg[0];
      cy = longint'(r.y) * ny / box_reg[1];
      cz = longint'(r.z) * nz / box_reg[2];
      if (r.mode == MODE_INSERT) begin
         flat = (cx * ny + cy) * nz + cz;
         if (flat >= 4096 || cell_fill[flat] >= 16) begin
            push_result(STATUS_FULL, '0, '0, 1'b1);
            return;
         end
         s = flat * 16 + cell_fill[flat];
         slot_id[s] = r.id;
         slot_x[s] = r.x;
         slot_y[s] = r.y;
         slot_z[s] = r.z;
         cell_fill[flat] = cell_fill[flat] + 1;
         push_result(STATUS_INSERTED, '0, '0, 1'b1);
         return;
      end
      lim = (limit_reg > 64) ? 64 : limit_reg;
      kx = neighbor_cells(cx, nx, lx);
      ky = neighbor_cells(cy, ny, ly);
      kz = neighbor_cells(cz, nz, lz);
      found = 0;
      for (int a = 0; a < kx; a++)
         for (int b = 0; b < ky; b++)
            for (int c = 0; c < kz; c++) begin
               flat = (lx[a] * ny + ly[b]) * nz + lz[c];
               if (flat < 4096) begin
                  for (int i = 0; i < cell_fill[flat]; i++) begin
                     s = flat * 16 + i;
                     if (found < lim && slot_id[s] != r.id) begin
                        d = wrap_gap_sq(r.x, slot_x[s], box_reg[0])
                          + wrap_gap_sq(r.y, slot_y[s], box_reg[1])
                          + wrap_gap_sq(r.z, slot_z[s], box_reg[2]);
                        if (d < cutoff_reg) begin
                           push_result(STATUS_NEIGHBOR, slot_id[s], d[43:0], 1'b0);
                           found++;
                        end
                     end
                  end
               end
            end
      if (found == 0) push_result(STATUS_NONE, '0, '0, 1'b1);
      else expected_results[$].last = 1'b1;
   endfunction

   // request driver
   always @(negedge clock) begin
      search_req_t item;
      if (!reset) begin
         if (req_bus.valid && !req_fired) begin
         end else if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap--;
         end else if (pending_requests.size() > 0) begin
            item = pending_requests.pop_front();
            req_bus.mode <= item.mode;
            req_bus.atom_id <= item.id;
            req_bus.pos_x <= item.x;
            req_bus.pos_y <= item.y;
            req_bus.pos_z <= item.z;
            req_bus.valid <= 1'b1;
            req_gap = idle_off ? 0 : $urandom_range(0, 9);
         end else begin
            req_bus.valid <= 1'b0;
         end
         req_fired = 0;
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold--;
      end else if (rsp_wait > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      search_req_t r;
      search_rsp_t e;
      if (!reset) begin
         quiet_cycles++;
         if (csr_bus.valid && csr_bus.ready) begin
            quiet_cycles = 0;
            case (csr_reg_type'(csr_bus.index))
               REG_CELLS_X:        grid_reg[0] = csr_bus.data[12:0];
               REG_CELLS_Y:        grid_reg[1] = csr_bus.data[12:0];
               REG_CELLS_Z:        grid_reg[2] = csr_bus.data[12:0];
               REG_BOX_LX:         box_reg[0] = csr_bus.data[21:0];
               REG_BOX_LY:         box_reg[1] = csr_bus.data[21:0];
               REG_BOX_LZ:         box_reg[2] = csr_bus.data[21:0];
               REG_CUTOFF_SQ:      cutoff_reg = csr_bus.data[43:0];
               REG_NEIGHBOR_LIMIT: limit_reg = csr_bus.data[6:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            quiet_cycles = 0;
            req_fired = 1;
            r.mode = req_bus.mode;
            r.id = req_bus.atom_id;
            r.x = req_bus.pos_x;
            r.y = req_bus.pos_y;
            r.z = req_bus.pos_z;
            predict_search(r);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            quiet_cycles = 0;
            rsp_wait = idle_off ? 0 : $urandom_range(0, 9);
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result status %0d id %0d dist %0d last %0d", $time,
                        rsp_bus.status, rsp_bus.neighbor_id, rsp_bus.neighbor_dist_sq,
                        rsp_bus.last);
            end else begin
               e = expected_results.pop_front();
               if (rsp_bus.status !== e.status || rsp_bus.neighbor_id !== e.id ||
                   rsp_bus.neighbor_dist_sq !== e.dist_sq || rsp_bus.last !== e.last) begin
                  errors++;
                  $display("%0t: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                           $time, e.status, e.id, e.dist_sq, e.last, rsp_bus.status,
                           rsp_bus.neighbor_id, rsp_bus.neighbor_dist_sq, rsp_bus.last);
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL cell_list_neighbor_search");
            $finish;
         end
      end
   end

   task automatic write_reg(csr_reg_type idx, longint unsigned value);
      @(negedge clock);
      csr_bus.index <= idx;
      csr_bus.data <= value[43:0];
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic configure(longint unsigned gx, longint unsigned gy, longint unsigned gz,
                            longint unsigned bx, longint unsigned by, longint unsigned bz,
                            longint unsigned cut, longint unsigned lim);
      write_reg(REG_CELLS_X, gx);
      write_reg(REG_CELLS_Y, gy);
      write_reg(REG_CELLS_Z, gz);
      write_reg(REG_BOX_LX, bx);
      write_reg(REG_BOX_LY, by);
      write_reg(REG_BOX_LZ, bz);
      write_reg(REG_CUTOFF_SQ, cut);
      write_reg(REG_NEIGHBOR_LIMIT, lim);
      @(posedge clock);
   endtask

   task automatic send(logic [1:0] mode, longint unsigned id, longint unsigned x,
                       longint unsigned y, longint unsigned z);
      search_req_t r;
      r.mode = mode;
      r.id = id[15:0];
      r.x = x[21:0];
      r.y = y[21:0];
      r.z = z[21:0];
      pending_requests.insert(pending_requests.size(), r);
      if (mode == MODE_INSERT) stored_atoms.insert(stored_atoms.size(), r);
      if (mode == MODE_CLEAR) stored_atoms.delete();
   endtask

   function automatic longint unsigned near_coord(longint unsigned base, int axis);
      longint unsigned j;
      j = box_reg[axis] / eff_cells(grid_reg[axis]) / 2 + 1;
      if (j > box_reg[axis]) j = box_reg[axis];
      return (base + box_reg[axis] * 2 + $urandom_range(0, 2 * j) - j) % box_reg[axis];
   endfunction

   task automatic random_phase(int n_items);
      longint unsigned cl, pos[3];
      int pick;
      search_req_t base;
      for (int k = 0; k < 3; k++) begin
         grid_reg[k] = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
         box_reg[k] = ($urandom_range(0, 5) == 0) ? COORD_MAX : $urandom_range(2000, COORD_MAX);
      end
      cl = box_reg[0] / eff_cells(grid_reg[0]);
      cl = cl * cl * $urandom_range(1, 4) / 2;
      if ($urandom_range(0, 7) == 0) cl = DIST_MAX;
      configure(grid_reg[0], grid_reg[1], grid_reg[2], box_reg[0], box_reg[1], box_reg[2],
                cl & DIST_MAX, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 127));
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(0, 99);
         for (int k = 0; k < 3; k++) pos[k] = $urandom_range(0, box_reg[k] - 1);
         if (stored_atoms.size() > 0 && $urandom_range(0, 2) != 0) begin
            base = stored_atoms[$urandom_range(0, stored_atoms.size() - 1)];
            pos[0] = near_coord(base.x, 0);
            pos[1] = near_coord(base.y, 1);
            pos[2] = near_coord(base.z, 2);
         end else begin
            base.id = $urandom_range(0, 65535);
         end
         if (pick < 45) begin
            send(MODE_INSERT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                 : $urandom_range(0, 63), pos[0], pos[1], pos[2]);
         end else if (pick < 85) begin
            send(MODE_QUERY, ($urandom_range(0, 3) == 0) ? base.id : $urandom_range(0, 65535),
                 pos[0], pos[1], pos[2]);
         end else if (pick < 91) begin
            pick = $urandom_range(0, 2);
            if (box_reg[pick] < COORD_MAX) pos[pick] = $urandom_range(box_reg[pick], COORD_MAX);
            send(($urandom_range(0, 1) == 0) ? MODE_INSERT : MODE_QUERY,
                 $urandom_range(0, 65535), pos[0], pos[1], pos[2]);
         end else if (pick < 96) begin
            send(MODE_UNUSED, $urandom_range(0, 65535), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
         end else begin
            send(MODE_CLEAR, $urandom_range(0, 65535), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
         end
      end
      drain();
   endtask

   initial begin
      errors = 0;
      req_gap = 0;
      rsp_wait = 0;
      rsp_hold = 0;
      req_fired = 0;
      idle_off = 0;
      quiet_cycles = 0;
      grid_reg = '{1, 1, 1};
      box_reg = '{COORD_MAX, COORD_MAX, COORD_MAX};
      cutoff_reg = 0;
      limit_reg = 64;
      foreach (cell_fill[i]) cell_fill[i] = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_INSERT;
      req_bus.atom_id = '0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_CELLS_X;
      csr_bus.data = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults: single cell, full box, zero cutoff
      send(MODE_INSERT, 0, 0, 0, 0);
      send(MODE_INSERT, 16'hFFFF, COORD_MAX - 1, COORD_MAX - 1, COORD_MAX - 1);
      send(MODE_QUERY, 1, 0, 0, 0);
      send(MODE_INSERT, 2, COORD_MAX, 0, 0);
      send(MODE_UNUSED, 16'hFFFF, COORD_MAX, COORD_MAX, COORD_MAX);
      send(MODE_CLEAR, 0, 0, 0, 0);
      drain();

      // zero cells, small box, widest cutoff, limit zero then saturated
      configure(0, 0, 0, 4096, 4096, 4096, DIST_MAX, 0);
      send(MODE_INSERT, 1, 0, 0, 0);
      send(MODE_INSERT, 2, 4095, 4095, 4095);
      send(MODE_QUERY, 3, 100, 100, 100);
      send(MODE_QUERY, 1, 0, 0, 4096);
      drain();
      write_reg(REG_NEIGHBOR_LIMIT, 127);
      send(MODE_QUERY, 3, 100, 100, 100);
      send(MODE_QUERY, 1, 0, 0, 0);
      drain();

      // oversized grid and a full cell
      configure(8191, 2, 1, COORD_MAX, COORD_MAX, COORD_MAX, DIST_MAX, 64);
      send(MODE_CLEAR, 0, 0, 0, 0);
      send(MODE_INSERT, 5, COORD_MAX - 1, 0, 0);
      send(MODE_QUERY, 6, COORD_MAX - 1, 0, 0);
      for (int i = 0; i < 17; i++) send(MODE_INSERT, 10 + i, i, 0, 0);
      drain();

      // narrow grid
      configure(2, 2, 2, 8192, 8192, 8192, DIST_MAX, 64);
      send(MODE_CLEAR, 0, 0, 0, 0);
      send(MODE_INSERT, 40, 10, 10, 10);
      send(MODE_INSERT, 41, 8000, 5000, 100);
      send(MODE_QUERY, 42, 4100, 4100, 4100);
      drain();

      for (int p = 0; p < 6; p++) begin
         idle_off = (p == 1);
         if (p % 2 == 0) begin
            send(MODE_CLEAR, 0, 0, 0, 0);
            drain();
         end
         if (p == 2) rsp_hold = 400;
         random_phase(50);
      end
      idle_off = 0;

      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("PASS cell_list_neighbor_search");
      end else begin
         $display("FAIL cell_list_neighbor_search");
      end
      $finish;
   end

endmodule
